### rtl/ifrq_pkg.sv
package ifrq_pkg;

    localparam int VAL_W = 32;
    localparam int DIM_W = 7;
    localparam int POS_W = 6;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_XFORM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] XF_VFLIP = 3'd0;
    localparam logic [2:0] XF_HFLIP = 3'd1;
    localparam logic [2:0] XF_RCW   = 3'd2;
    localparam logic [2:0] XF_RCCW  = 3'd3;
    localparam logic [2:0] XF_QCW   = 3'd4;
    localparam logic [2:0] XF_QCCW  = 3'd5;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    typedef struct packed {
        logic [1:0]       op;
        logic [2:0]       transform;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [DIM_W-1:0] cur_rows;
        logic [DIM_W-1:0] cur_cols;
    } t_out_word;

    typedef struct packed {
        logic [2:0]       xf;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_map_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_XFORM,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

### rtl/ifrq_src_map.sv
module ifrq_src_map import ifrq_pkg::*; #(
    parameter int AW = 6
) (
    input  t_map_ctrl         i_ctrl,
    input  logic [AW-1:0]     i_i,
    input  logic [AW-1:0]     i_j,
    output logic [AW-1:0]     o_si,
    output logic [AW-1:0]     o_sj,
    output logic [DIM_W-1:0]  o_new_rows,
    output logic [DIM_W-1:0]  o_new_cols
);

    localparam int CW = AW + 8;

    logic [CW-1:0] n, m, h, w, ii, jj, nn, nm, si, sj;
    logic          rot;

    always_comb begin
        n   = CW'(i_ctrl.rows);
        m   = CW'(i_ctrl.cols);
        h   = n >> 1;
        w   = m >> 1;
        ii  = CW'(i_i);
        jj  = CW'(i_j);
        rot = (i_ctrl.xf == XF_RCW) || (i_ctrl.xf == XF_RCCW);
        nn  = rot ? m : n;
        nm  = rot ? n : m;
        si  = ii;
        sj  = jj;
        unique case (i_ctrl.xf)
            XF_VFLIP: begin
                si = n - CW'(1) - ii;
            end
            XF_HFLIP: begin
                sj = m - CW'(1) - jj;
            end
            XF_RCW: begin
                si = n - CW'(1) - jj;
                sj = ii;
            end
            XF_RCCW: begin
                si = jj;
                sj = m - CW'(1) - ii;
            end
            XF_QCW: begin
                priority if (ii < h && jj < w) begin
                    si = ii + h;
                end else if (jj < w) begin
                    sj = jj + w;
                end else if (ii >= h) begin
                    si = ii - h;
                end else begin
                    sj = jj - w;
                end
            end
            default: begin
                priority if (ii < h && jj < w) begin
                    sj = jj + w;
                end else if (ii < h) begin
                    si = ii + h;
                end else if (jj >= w) begin
                    sj = jj - w;
                end else begin
                    si = ii - h;
                end
            end
        endcase
        // Positions outside the new shape copy their own old element.
        if (!(ii < nn && jj < nm)) begin
            si = ii;
            sj = jj;
        end
    end

    assign o_si       = si[AW-1:0];
    assign o_sj       = sj[AW-1:0];
    assign o_new_rows = nn[DIM_W-1:0];
    assign o_new_cols = nm[DIM_W-1:0];

endmodule

### rtl/image_flip_rotate_quadrant_engine.sv
// Write, unknown-op and bad-transform words: result registered at the accepting edge.
// Read words: registered memory read, then S_READ and S_DONE, then the output register.
// Transform words: one pass over all MAX_DIM*MAX_DIM positions, one memory read and
// write per cycle, then the S_DRAIN and S_DONE states.
// A word is taken only as or after the previous result leaves, so one word at a time.
// Synchronous active-low reset restores the 64 by 64 shape; the memory is not cleared.
module image_flip_rotate_quadrant_engine import ifrq_pkg::*; #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data
);

    localparam int AW       = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W   = 2 * AW + 1;
    localparam int DEPTH    = 2 ** ADDR_W;
    localparam int CW       = AW + 8;
    localparam int EVEN_MAX = (MAX_DIM / 2) * 2;
    localparam logic [DIM_W-1:0] EVEN_CAP = (EVEN_MAX > 126) ? DIM_W'(126) : DIM_W'(EVEN_MAX);
    localparam logic [DIM_W-1:0] DIM_RST  = DIM_W'(64);
    localparam logic [AW-1:0]    LAST     = AW'(MAX_DIM - 1);

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = {v[DIM_W-1:1], 1'b0};
        if (d == '0) d = DIM_W'(2);
        if (d > EVEN_CAP) d = EVEN_CAP;
        return d;
    endfunction

    t_state                r_state, n_state;
    logic [DIM_W-1:0]      r_cfg_rows, r_cfg_cols;
    logic [DIM_W-1:0]      r_cur_rows, n_cur_rows, r_cur_cols, n_cur_cols;
    logic                  r_active, n_active;
    logic [2:0]            r_xf, n_xf;
    logic [AW-1:0]         r_i, n_i, r_j, n_j;
    logic                  r_rd_in, n_rd_in;
    logic [VAL_W-1:0]      r_res_val, n_res_val;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;
    logic                  r_wr_vld, n_wr_vld;
    logic [ADDR_W-1:0]     r_wr_addr, n_wr_addr;
    logic [DATA_WIDTH-1:0] r_mem_q;
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic                  out_free, in_fire;
    logic [CW-1:0]         row_x, col_x;
    logic [AW-1:0]         row_a, col_a;
    logic [DIM_W-1:0]      eff_rows, eff_cols;
    logic                  wr_shape, rd_shape;
    t_map_ctrl             map_ctrl;
    logic [AW-1:0]         map_si, map_sj;
    logic [DIM_W-1:0]      map_rows, map_cols;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_fire    = i_in_valid && !o_in_stall;

    assign row_x    = CW'(i_in.row);
    assign col_x    = CW'(i_in.col);
    assign row_a    = row_x[AW-1:0];
    assign col_a    = col_x[AW-1:0];
    assign eff_rows = eff_dim(r_cfg_rows);
    assign eff_cols = eff_dim(r_cfg_cols);
    assign wr_shape = (row_x < CW'(eff_rows)) && (col_x < CW'(eff_cols));
    assign rd_shape = (row_x < CW'(r_cur_rows)) && (col_x < CW'(r_cur_cols));

    assign map_ctrl = '{xf: r_xf, rows: r_cur_rows, cols: r_cur_cols};

    ifrq_src_map #(
        .AW(AW)
    ) u_map (
        .i_ctrl     (map_ctrl),
        .i_i        (r_i),
        .i_j        (r_j),
        .o_si       (map_si),
        .o_sj       (map_sj),
        .o_new_rows (map_rows),
        .o_new_cols (map_cols)
    );

    always_comb begin
        n_state     = r_state;
        n_cur_rows  = r_cur_rows;
        n_cur_cols  = r_cur_cols;
        n_active    = r_active;
        n_xf        = r_xf;
        n_i         = r_i;
        n_j         = r_j;
        n_rd_in     = r_rd_in;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_wr_vld    = 1'b0;
        n_wr_addr   = {~r_active, r_i, r_j};
        mem_we      = r_wr_vld;
        mem_waddr   = r_wr_addr;
        mem_wdata   = r_mem_q;
        mem_re      = 1'b0;
        mem_raddr   = {r_active, map_si, map_sj};
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.op)
                        OP_WRITE: begin
                            n_cur_rows  = eff_rows;
                            n_cur_cols  = eff_cols;
                            mem_we      = wr_shape;
                            mem_waddr   = {r_active, row_a, col_a};
                            mem_wdata   = DATA_WIDTH'(i_in.value);
                            n_out_valid = 1'b1;
                            n_out       = '{read_value: '0, cur_rows: eff_rows,
                                            cur_cols: eff_cols};
                        end
                        OP_XFORM: begin
                            if (i_in.transform <= XF_QCCW) begin
                                n_xf      = i_in.transform;
                                n_i       = '0;
                                n_j       = '0;
                                n_res_val = '0;
                                n_state   = S_XFORM;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out       = '{read_value: '0, cur_rows: r_cur_rows,
                                                cur_cols: r_cur_cols};
                            end
                        end
                        OP_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = {r_active, row_a, col_a};
                            n_rd_in   = rd_shape;
                            n_state   = S_READ;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out       = '{read_value: '0, cur_rows: r_cur_rows,
                                            cur_cols: r_cur_cols};
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_val = r_rd_in ? VAL_W'(r_mem_q) : '0;
                n_state   = S_DONE;
            end
            S_XFORM: begin
                mem_re   = 1'b1;
                n_wr_vld = 1'b1;
                if (r_j == LAST) begin
                    n_j = '0;
                    if (r_i == LAST) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_i = r_i + AW'(1);
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DRAIN: begin
                n_cur_rows = map_rows;
                n_cur_cols = map_cols;
                n_active   = ~r_active;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{read_value: r_res_val, cur_rows: r_cur_rows,
                                    cur_cols: r_cur_cols};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_rows  <= eff_dim(DIM_RST);
            r_cur_cols  <= eff_dim(DIM_RST);
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_rows  <= n_cur_rows;
            r_cur_cols  <= n_cur_cols;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_wr_vld    <= n_wr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= DIM_RST;
            r_cfg_cols <= DIM_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ROWS) r_cfg_rows <= i_cfg_data;
            if (i_cfg_idx == CFG_COLS) r_cfg_cols <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xf      <= n_xf;
        r_i       <= n_i;
        r_j       <= n_j;
        r_rd_in   <= n_rd_in;
        r_res_val <= n_res_val;
        r_out     <= n_out;
        r_wr_addr <= n_wr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_mem_q <= r_mem[mem_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/ifrq_checker.sv
module ifrq_checker import ifrq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out
);

    logic in_fire;
    assign in_fire = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result word changed");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input word taken while result slot blocked");

    a_shape_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out.cur_rows[0] && !o_out.cur_cols[0]
                        && o_out.cur_rows != '0 && o_out.cur_cols != '0)
        else $error("reported shape not even and non-zero");

    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in.op == OP_WRITE) |=> o_out_valid && o_out.read_value == '0)
        else $error("write word gave no immediate result");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in.op == OP_READ) |=> o_in_stall)
        else $error("read word did not hold off the next word");

endmodule

bind image_flip_rotate_quadrant_engine ifrq_checker u_ifrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
